// File: rtl/kvt_pkg.sv
// Shared types and constants for the thread key/value table.
// No dependencies; used by kvt_entry_store and thread_key_value_table.
package kvt_pkg;

	localparam int KEY_COUNT_DEF   = 16;
	localparam int ENTRY_COUNT_DEF = 32;
	localparam int TID_W           = 15;
	localparam int VALUE_W         = 32;
	localparam int CKEY_W          = 4;

	// request modes
	localparam logic [1:0] MODE_CREATE = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_GET    = 2'd2;
	localparam logic [1:0] MODE_SET    = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVAL   = 3'd1;
	localparam logic [2:0] ST_NOKEY   = 3'd2;
	localparam logic [2:0] ST_NOSPACE = 3'd3;
	localparam logic [2:0] ST_GETFAIL = 3'd4;

	typedef enum logic [1:0] {
		KVT_IDLE,
		KVT_KEYSCAN,
		KVT_ENTSCAN
	} kvt_state_t;

	// controller -> entry store
	typedef struct packed {
		logic start;
		logic write;
		logic clear;
	} kvt_cmd_t;

	// entry store -> controller
	typedef struct packed {
		logic done;
		logic found;
		logic free_found;
	} kvt_sts_t;

endpackage

// File: rtl/kvt_entry_ram.sv
// Single-port-write, single-port-read entry memory with registered read data.
// Depends on nothing; instantiated by kvt_entry_store.
module kvt_entry_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 51,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/kvt_entry_store.sv
// Entry table: in-use bits, entry memory and the sequential match/free scan.
// Depends on kvt_pkg and kvt_entry_ram.
module kvt_entry_store #(
	parameter int KEY_W = 4,
	parameter int ENTRY_COUNT = kvt_pkg::ENTRY_COUNT_DEF,
	localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kvt_pkg::kvt_cmd_t          cmd,
	input  logic [KEY_W-1:0]           key,
	input  logic [kvt_pkg::TID_W-1:0]  tid,
	input  logic [kvt_pkg::VALUE_W-1:0] wr_value,
	input  logic [IDX_W-1:0]           wr_idx,
	output kvt_pkg::kvt_sts_t          sts,
	output logic [IDX_W-1:0]           match_idx,
	output logic [kvt_pkg::VALUE_W-1:0] match_value,
	output logic [IDX_W-1:0]           free_idx
);

	localparam int WIDTH = KEY_W + kvt_pkg::TID_W + kvt_pkg::VALUE_W;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRY_COUNT - 1);

	logic [ENTRY_COUNT-1:0] vld_q;
	logic                   issue_q;
	logic [IDX_W-1:0]       addr_q;
	logic                   rd_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   vld_s1;
	logic                   found_q;
	logic                   free_found_q;
	logic                   done_q;
	logic [IDX_W-1:0]       match_idx_q;
	logic [IDX_W-1:0]       free_idx_q;
	logic [kvt_pkg::VALUE_W-1:0] match_value_q;
	logic [WIDTH-1:0]       rdata;
	logic [KEY_W-1:0]       rd_key;
	logic [kvt_pkg::TID_W-1:0] rd_tid;
	logic [kvt_pkg::VALUE_W-1:0] rd_value;
	logic                   hit;

	kvt_entry_ram #(
		.DEPTH(ENTRY_COUNT),
		.WIDTH(WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (wr_idx),
		.wdata ({key, tid, wr_value}),
		.re    (issue_q),
		.raddr (addr_q),
		.rdata (rdata)
	);

	assign {rd_key, rd_tid, rd_value} = rdata;
	assign hit = rd_s1 && vld_s1 && (rd_key == key) && (rd_tid == tid);

	// in-use bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.write) begin
			vld_q[wr_idx] <= 1'b1;
		end else if (cmd.clear) begin
			vld_q[wr_idx] <= 1'b0;
		end
	end

	// scan control: issue one address a cycle, compare in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q      <= 1'b0;
			addr_q       <= '0;
			rd_s1        <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= rd_s1 && (idx_s1 == LAST);
			rd_s1  <= issue_q;
			if (cmd.start) begin
				issue_q      <= 1'b1;
				addr_q       <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (issue_q) begin
					if (addr_q == LAST) begin
						issue_q <= 1'b0;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				if (hit && !found_q) begin
					found_q <= 1'b1;
				end
				if (rd_s1 && !vld_s1 && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		vld_s1 <= vld_q[addr_q];
		if (hit && !found_q) begin
			match_idx_q   <= idx_s1;
			match_value_q <= rd_value;
		end
		if (rd_s1 && !vld_s1 && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
	end

	assign sts.done       = done_q;
	assign sts.found      = found_q;
	assign sts.free_found = free_found_q;
	assign match_idx      = match_idx_q;
	assign match_value    = match_value_q;
	assign free_idx       = free_idx_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !issue_q && !rd_s1)
		else $error("scan restarted while running");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.write || cmd.clear) |-> !issue_q && !rd_s1)
		else $error("entry table modified during scan");

	a_match_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && found_q) |-> vld_q[match_idx_q])
		else $error("matched entry is not in use");

	a_free_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && free_found_q) |-> !vld_q[free_idx_q])
		else $error("free entry is in use");

endmodule

// File: rtl/thread_key_value_table.sv
// Thread key/value table top level: request decode, key bitmap, result register.
// Depends on kvt_pkg and kvt_entry_store.
//
// One request at a time: a request is taken when start is high and busy is
// low, and its single result appears on status/created_key/read_value for
// exactly one cycle with done high; the result cannot be held off, so the
// receiver must take it in that cycle. Delete and any request rejected on its
// key or thread id give their result in the cycle after acceptance. Create
// walks the key bitmap one key per cycle, lowest first, and stops at the first
// free key or after the last key. Get and set that pass the checks scan every
// entry of the entry memory through its single read port, one entry per cycle
// with registered read data, then commit at most one write or clear. busy
// falls in the cycle that shows the result, so the next request may be started
// there. Reset clears the in-use flip-flops and the control registers but not
// the entry memory; the block is ready in the first cycle after reset.
module thread_key_value_table #(
	parameter int KEY_COUNT   = kvt_pkg::KEY_COUNT_DEF,
	parameter int ENTRY_COUNT = kvt_pkg::ENTRY_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic signed [7:0]  key_index,
	input  logic signed [15:0] thread_id,
	input  logic [31:0] new_value,
	input  logic        value_present,
	output logic        done,
	output logic [2:0]  status,
	output logic [3:0]  created_key,
	output logic [31:0] read_value
);

	localparam int KEY_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam logic [KEY_W-1:0] KEY_LAST = KEY_W'(KEY_COUNT - 1);

	kvt_pkg::kvt_state_t state_q, state_d;

	// latched request
	logic [1:0]                  mode_q;
	logic [KEY_W-1:0]            key_q;
	logic [kvt_pkg::TID_W-1:0]   tid_q;
	logic [kvt_pkg::VALUE_W-1:0] value_q;
	logic                        present_q;

	logic [KEY_COUNT-1:0] key_in_use_q;
	logic [KEY_W-1:0]     kscan_q, kscan_d;

	// result register
	logic        done_q;
	logic [2:0]  status_q;
	logic [3:0]  created_q;
	logic [31:0] read_q;

	// decode of the incoming request
	logic             in_key_ok;
	logic [KEY_W-1:0] in_key;
	logic             in_key_used;

	// controller outputs
	logic        latch;
	logic        fin;
	logic [2:0]  fin_status;
	logic [3:0]  fin_created;
	logic [31:0] fin_value;
	logic        key_set_en;
	logic        key_clr_en;

	kvt_pkg::kvt_cmd_t scan_cmd;
	kvt_pkg::kvt_sts_t scan_sts;
	logic [IDX_W-1:0]  wr_idx;
	logic [IDX_W-1:0]  match_idx;
	logic [IDX_W-1:0]  free_idx;
	logic [kvt_pkg::VALUE_W-1:0] match_value;

	// key valid when 0 <= key < KEY_COUNT
	assign in_key_ok   = !key_index[7] && (key_index[6:0] < 7'(KEY_COUNT));
	assign in_key      = key_index[KEY_W-1:0];
	assign in_key_used = in_key_ok ? key_in_use_q[in_key] : 1'b0;

	// lowest matching entry wins; otherwise the lowest free one
	assign wr_idx = scan_sts.found ? match_idx : free_idx;

	kvt_entry_store #(
		.KEY_W       (KEY_W),
		.ENTRY_COUNT (ENTRY_COUNT)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (scan_cmd),
		.key         (key_q),
		.tid         (tid_q),
		.wr_value    (value_q),
		.wr_idx      (wr_idx),
		.sts         (scan_sts),
		.match_idx   (match_idx),
		.match_value (match_value),
		.free_idx    (free_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kvt_pkg::KVT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control
	always_comb begin
		state_d     = state_q;
		kscan_d     = kscan_q;
		latch       = 1'b0;
		fin         = 1'b0;
		fin_status  = kvt_pkg::ST_OK;
		fin_created = '0;
		fin_value   = '0;
		key_set_en  = 1'b0;
		key_clr_en  = 1'b0;
		scan_cmd    = '0;
		unique case (state_q)
			kvt_pkg::KVT_IDLE: begin
				if (start) begin
					latch = 1'b1;
					unique case (mode)
						kvt_pkg::MODE_CREATE: begin
							state_d = kvt_pkg::KVT_KEYSCAN;
							kscan_d = '0;
						end
						kvt_pkg::MODE_DELETE: begin
							fin = 1'b1;
							if (!in_key_ok) begin
								fin_status = kvt_pkg::ST_INVAL;
							end else if (!in_key_used) begin
								fin_status = kvt_pkg::ST_NOKEY;
							end else begin
								key_clr_en = 1'b1;
							end
						end
						kvt_pkg::MODE_GET: begin
							if (thread_id[15] || !in_key_used) begin
								fin        = 1'b1;
								fin_status = kvt_pkg::ST_GETFAIL;
							end else begin
								state_d        = kvt_pkg::KVT_ENTSCAN;
								scan_cmd.start = 1'b1;
							end
						end
						kvt_pkg::MODE_SET: begin
							if (thread_id[15] || !in_key_ok) begin
								fin        = 1'b1;
								fin_status = kvt_pkg::ST_INVAL;
							end else if (!in_key_used) begin
								fin        = 1'b1;
								fin_status = kvt_pkg::ST_NOKEY;
							end else begin
								state_d        = kvt_pkg::KVT_ENTSCAN;
								scan_cmd.start = 1'b1;
							end
						end
					endcase
				end
			end
			kvt_pkg::KVT_KEYSCAN: begin
				// one key per cycle, lowest first
				if (!key_in_use_q[kscan_q]) begin
					fin         = 1'b1;
					key_set_en  = 1'b1;
					fin_created = 4'(kscan_q);
				end else if (kscan_q == KEY_LAST) begin
					fin        = 1'b1;
					fin_status = kvt_pkg::ST_NOSPACE;
				end else begin
					kscan_d = kscan_q + 1'b1;
				end
			end
			kvt_pkg::KVT_ENTSCAN: begin
				if (scan_sts.done) begin
					fin = 1'b1;
					if (mode_q == kvt_pkg::MODE_GET) begin
						if (scan_sts.found) begin
							fin_value = match_value;
						end else begin
							fin_status = kvt_pkg::ST_GETFAIL;
						end
					end else if (present_q) begin
						if (scan_sts.found || scan_sts.free_found) begin
							scan_cmd.write = 1'b1;
						end else begin
							fin_status = kvt_pkg::ST_NOSPACE;
						end
					end else if (scan_sts.found) begin
						// null value removes the matching entry
						scan_cmd.clear = 1'b1;
					end
				end
			end
			default: begin
				state_d = kvt_pkg::KVT_IDLE;
			end
		endcase
		if (fin) begin
			state_d = kvt_pkg::KVT_IDLE;
		end
	end

	// key bitmap; delete leaves the key's entries in place
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_in_use_q <= '0;
		end else if (key_set_en) begin
			key_in_use_q[kscan_q] <= 1'b1;
		end else if (key_clr_en) begin
			key_in_use_q[in_key] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kscan_q <= '0;
			done_q  <= 1'b0;
		end else begin
			kscan_q <= kscan_d;
			done_q  <= fin;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (latch) begin
			mode_q    <= mode;
			key_q     <= in_key;
			tid_q     <= thread_id[kvt_pkg::TID_W-1:0];
			value_q   <= new_value;
			present_q <= value_present;
		end
		if (fin) begin
			status_q  <= fin_status;
			created_q <= fin_created;
			read_q    <= fin_value;
		end
	end

	assign busy        = (state_q != kvt_pkg::KVT_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign created_key = created_q;
	assign read_value  = read_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != kvt_pkg::ST_OK) |-> created_key == 4'd0 && read_value == 32'd0)
		else $error("failed request returned nonzero payload");

	a_scan_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		scan_sts.done |-> state_q == kvt_pkg::KVT_ENTSCAN)
		else $error("entry scan finished outside of a get or set");

	a_create_sets_key: assert property (@(posedge clk) disable iff (!arst_n)
		key_set_en |=> key_in_use_q[$past(kscan_q)])
		else $error("created key not marked in use");

endmodule
